// ----- hdl/fos_pkg.sv -----
// shared constants and types for the frequency order sorter
package fos_pkg;

    // element width and default set size
    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    // command broadcast from the control logic to every cell
    typedef struct packed {
        logic load;       // a request is being counted this cycle
        logic alloc;      // no cell matched, the first empty cell takes the value
        logic sort_even;  // compare-exchange on pairs (0,1), (2,3), ...
        logic sort_odd;   // compare-exchange on pairs (1,2), (3,4), ...
        logic shift;      // whole chain moves one place towards the head
        logic dec_head;   // head cell gives out one copy and keeps the rest
    } t_cell_cmd;

endpackage

// ----- hdl/fos_cell.sv -----
// one cell of the chain: a distinct value, its count and the neighbour exchange
module fos_cell import fos_pkg::*; #(
    parameter int CNT_W   = 7,
    parameter bit IS_EVEN = 1'b1,
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_left_used,
    input  logic signed [DATA_W-1:0] i_left_value,
    input  logic [CNT_W-1:0]         i_left_count,
    input  logic signed [DATA_W-1:0] i_right_value,
    input  logic [CNT_W-1:0]         i_right_count,
    output logic signed [DATA_W-1:0] o_value,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_match
);

    logic signed [DATA_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     w_used;
    logic                     w_pair_right;
    logic                     w_pair_left;

    assign w_used  = (r_count != '0);
    assign o_match = w_used && (r_value == i_value);

    // which neighbour this cell is paired with in the current sort phase
    assign w_pair_right = (i_cmd.sort_even && IS_EVEN) || (i_cmd.sort_odd && !IS_EVEN);
    assign w_pair_left  = (i_cmd.sort_even && !IS_EVEN) || (i_cmd.sort_odd && IS_EVEN);

    // next state of the cell
    always_comb begin
        n_value = r_value;
        n_count = r_count;
        if (i_cmd.load && o_match) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.alloc && !w_used && i_left_used) begin
            n_value = i_value;
            n_count = CNT_W'(1);
        end else if (w_pair_right && (i_right_count > r_count)) begin
            n_value = i_right_value;
            n_count = i_right_count;
        end else if (w_pair_left && (r_count > i_left_count)) begin
            n_value = i_left_value;
            n_count = i_left_count;
        end else if (i_cmd.shift) begin
            n_value = i_right_value;
            n_count = i_right_count;
        end else if (IS_HEAD && i_cmd.dec_head) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // count is control state, value is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_count = r_count;

endmodule

// ----- hdl/frequency_order_sorter_top.sv -----
// The odd-even sort starts once the request with the last flag is taken; results follow the last sort phase.
// Throughput: one element per cycle while loading; one result per cycle while emitting.
// busy stays high through the odd-even sort in the cell chain and the emission of every
// counted element of the set; results cannot be stalled by the receiver.
// Reset (synchronous, active low) empties every cell and returns to idle.
module frequency_order_sorter_top import fos_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_element_value,
    input  logic                     i_last_element,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_output
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int PH_W  = $clog2(MAX_ELEMENTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic [CNT_W-1:0] r_loaded, n_loaded;

    logic signed [DATA_W-1:0] w_value [MAX_ELEMENTS];
    logic [CNT_W-1:0]         w_count [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]  w_match;

    logic      w_accept;
    logic      w_room;
    logic      w_last_out;
    t_cell_cmd w_cmd;

    assign w_accept   = start && !busy;
    assign w_room     = (r_loaded < CNT_W'(MAX_ELEMENTS));
    assign w_last_out = (w_count[0] == CNT_W'(1)) && (w_count[1] == '0);

    // commands for the chain
    always_comb begin
        w_cmd           = '0;
        w_cmd.load      = w_accept && w_room;
        w_cmd.alloc     = w_accept && w_room && !(|w_match);
        w_cmd.sort_even = (r_state == ST_SORT) && !r_phase[0];
        w_cmd.sort_odd  = (r_state == ST_SORT) && r_phase[0];
        w_cmd.shift     = (r_state == ST_EMIT) && (w_count[0] == CNT_W'(1));
        w_cmd.dec_head  = (r_state == ST_EMIT) && (w_count[0] != CNT_W'(1));
    end

    // row of cells, head at index zero
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic                     w_left_used;
        logic signed [DATA_W-1:0] w_left_value;
        logic [CNT_W-1:0]         w_left_count;
        logic signed [DATA_W-1:0] w_right_value;
        logic [CNT_W-1:0]         w_right_count;

        if (g == 0) begin : g_head
            assign w_left_used  = 1'b1;
            assign w_left_value = '0;
            assign w_left_count = '1;
        end else begin : g_body
            assign w_left_used  = (w_count[g-1] != '0);
            assign w_left_value = w_value[g-1];
            assign w_left_count = w_count[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_count = '0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_count = w_count[g+1];
        end

        fos_cell #(
            .CNT_W   (CNT_W),
            .IS_EVEN ((g % 2) == 0),
            .IS_HEAD (g == 0)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_value       (i_element_value),
            .i_left_used   (w_left_used),
            .i_left_value  (w_left_value),
            .i_left_count  (w_left_count),
            .i_right_value (w_right_value),
            .i_right_count (w_right_count),
            .o_value       (w_value[g]),
            .o_count       (w_count[g]),
            .o_match       (w_match[g])
        );
    end

    // load, sort and emit sequencing
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_loaded = r_loaded;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_loaded = r_loaded + CNT_W'(1);
                    end
                    if (i_last_element) begin
                        n_state = ST_SORT;
                        n_phase = '0;
                    end
                end
            end
            ST_SORT: begin
                n_phase = r_phase + PH_W'(1);
                if (r_phase == PH_W'(MAX_ELEMENTS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_last_out) begin
                    n_state  = ST_IDLE;
                    n_loaded = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= '0;
            r_loaded <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_loaded <= n_loaded;
        end
    end

    // results come straight from the head cell
    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_EMIT);
    assign o_sorted_value = w_value[0];
    assign o_final_output = o_valid && w_last_out;

`ifndef SYNTH
    // the head never runs dry while results are being given out
    a_head_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (w_count[0] != '0))
        else $error("head cell empty during emission");

    // the final result returns the block to idle with the chain empty
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_output |=> ((r_state == ST_IDLE) && (w_count[0] == '0)))
        else $error("chain not empty after final result");

    // the sort hands over to emission after its last phase
    a_sort_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SORT) && (r_phase == PH_W'(MAX_ELEMENTS - 1)))
        |=> (r_state == ST_EMIT))
        else $error("sort did not hand over to emission");

    // an empty head cell has no occupied cell directly behind it
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_count[0] == '0) |-> (w_count[1] == '0))
        else $error("gap behind an empty head cell");

    // no more elements are counted than the set can hold
    a_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loaded <= CNT_W'(MAX_ELEMENTS)))
        else $error("element count overflow");
`endif

endmodule

// ----- dv/frequency_order_sorter_top_test.sv -----
// self-checking testbench for the frequency order sorter top level
module frequency_order_sorter_top_test;
    import fos_pkg::*;

    localparam int SET_MAX        = MAX_ELEMENTS_DEF;
    localparam int REQUEST_TARGET = 430;
    localparam int QUIET_FROM     = 360;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int REPORT_MAX     = 10;

    typedef logic signed [DATA_W-1:0] t_elem;

    typedef struct packed {
        t_elem sorted_value;
        logic  final_output;
    } t_sorted_result;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_elem i_element_value;
    logic  i_last_element;
    logic  o_valid;
    t_elem o_sorted_value;
    logic  o_final_output;

    int unsigned cycle_count;
    int unsigned requests_sent;
    bit          idle_on;

    // tallies each set and queues the frequency ordered values it should produce
    class freq_scoreboard;
        t_elem          distinct_vals[SET_MAX];
        logic [6:0]     tally[SET_MAX];
        int unsigned    n_distinct;
        int unsigned    n_loaded;
        t_sorted_result sorted_q[$];
        int unsigned    mismatches;

        function void clear_set();
            foreach (tally[i]) tally[i] = '0;
            n_distinct = 0;
            n_loaded   = 0;
        endfunction

        function void note_request(t_elem value, logic last);
            bit             found;
            t_sorted_result r;
            found = 0;
            // count the element unless the set is already full
            if (n_loaded < SET_MAX) begin
                for (int i = 0; i < n_distinct; i++) begin
                    if (!found && distinct_vals[i] == value) begin
                        tally[i] = tally[i] + 7'd1;
                        found = 1;
                    end
                end
                if (!found) begin
                    distinct_vals[n_distinct] = value;
                    tally[n_distinct] = 7'd1;
                    n_distinct++;
                end
                n_loaded++;
            end
            if (!last) return;
            // highest count first, equal counts in order of first appearance
            for (int cnt = SET_MAX; cnt >= 1; cnt--) begin
                for (int i = 0; i < n_distinct; i++) begin
                    if (tally[i] == cnt) begin
                        repeat (cnt) begin
                            r.sorted_value = distinct_vals[i];
                            r.final_output = 1'b0;
                            sorted_q = {sorted_q, r};
                        end
                    end
                end
            end
            if (sorted_q.size() > 0) sorted_q[sorted_q.size()-1].final_output = 1'b1;
            clear_set();
        endfunction

        function void check_result(t_elem value, logic final_flag);
            t_sorted_result want;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: value %0d final %0b", value, final_flag);
                return;
            end
            want = sorted_q.pop_front();
            if (want.sorted_value !== value || want.final_output !== final_flag) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected value %0d final %0b, got value %0d final %0b",
                             want.sorted_value, want.final_output, value, final_flag);
            end
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    freq_scoreboard order_board;

    frequency_order_sorter_top #(
        .MAX_ELEMENTS(SET_MAX)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_element_value(i_element_value),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_final_output (o_final_output)
    );

    // clock, period of two units
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog, request capture and result checking
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("frequency_order_sorter_top_test: errors");
            $finish;
        end else if (i_rst_n) begin
            if (start && !busy) order_board.note_request(i_element_value, i_last_element);
            if (o_valid) order_board.check_result(o_sorted_value, o_final_output);
        end
    end

    // present one request and hold it until the block takes it
    task automatic send_element(input t_elem value, input logic last);
        bit taken;
        taken = 0;
        @(negedge i_clk);
        start           <= 1'b1;
        i_element_value <= value;
        i_last_element  <= last;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        requests_sent++;
    endtask

    // sender gap with noise on the data lines
    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start           <= 1'b0;
            i_element_value <= t_elem'($urandom);
            i_last_element  <= 1'($urandom_range(0, 1));
        end
    endtask

    // drive a whole set, last flag on the final element
    task automatic send_set(input t_elem vals[$]);
        for (int i = 0; i < vals.size(); i++) begin
            if (idle_on && requests_sent < QUIET_FROM && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 8));
            send_element(vals[i], logic'(i == vals.size() - 1));
        end
    endtask

    function automatic t_elem pick_value();
        case ($urandom_range(0, 11))
            0:       return t_elem'(32'h8000_0000);
            1:       return t_elem'(32'h7fff_ffff);
            2:       return '0;
            3:       return '1;
            default: return t_elem'($urandom);
        endcase
    endfunction

    initial begin
        t_elem set_q[$];
        t_elem pool[SET_MAX];
        int    set_len;
        int    pool_n;
        int    kind;
        int    set_no;

        order_board = new();
        order_board.clear_set();
        order_board.mismatches = 0;
        cycle_count     = 0;
        requests_sent   = 0;
        idle_on         = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_element_value = '0;
        i_last_element  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes with ties, min and max winning by count
        set_q = '{t_elem'(32'h8000_0000), t_elem'(32'h7fff_ffff), '0, '1,
                  t_elem'(32'h7fff_ffff), t_elem'(32'h8000_0000), t_elem'(32'h7fff_ffff)};
        send_set(set_q);
        // single element set
        set_q = '{t_elem'(5)};
        send_set(set_q);
        // all counts equal, order of first appearance kept
        set_q = '{t_elem'(3), t_elem'(1), t_elem'(2), t_elem'(-7)};
        send_set(set_q);
        // later value overtakes an earlier one
        set_q = '{t_elem'(9), t_elem'(4), t_elem'(4), t_elem'(-9), t_elem'(4), t_elem'(9)};
        send_set(set_q);

        // random sets, the first two forced to the size limits
        set_no = 0;
        while (requests_sent < REQUEST_TARGET) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (set_no == 0) kind = 0;
            else if (set_no == 1) kind = 1;
            else kind = $urandom_range(0, 19);
            case (kind)
                0: begin
                    // full or overlong set, last flag may be on an ignored request
                    set_len = $urandom_range(64, 70);
                    pool_n  = (set_no == 0 || $urandom_range(0, 1)) ? SET_MAX
                                                                   : $urandom_range(2, 10);
                end
                1: begin
                    set_len = $urandom_range(64, 66);
                    pool_n  = 1;
                end
                default: begin
                    set_len = $urandom_range(1, 12);
                    pool_n  = $urandom_range(1, 6);
                end
            endcase
            for (int i = 0; i < pool_n; i++) pool[i] = pick_value();
            set_q.delete();
            for (int i = 0; i < set_len; i++) begin
                if (pool_n == SET_MAX && i < SET_MAX) set_q = {set_q, pool[i]};
                else set_q = {set_q, pool[$urandom_range(0, pool_n - 1)]};
            end
            send_set(set_q);
            // hold off once until the block has drained
            if (set_no == 6) begin
                @(negedge i_clk);
                start <= 1'b0;
                while (order_board.pending() != 0) @(negedge i_clk);
            end
            set_no++;
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (order_board.pending() != 0) @(negedge i_clk);
        repeat (2 * SET_MAX + 8) @(negedge i_clk);

        if (order_board.pending() != 0)
            $display("%0d expected results never arrived", order_board.pending());
        if (order_board.mismatches == 0 && order_board.pending() == 0) begin
            $display("frequency_order_sorter_top_test: clean");
        end else begin
            $display("frequency_order_sorter_top_test: errors");
        end
        $finish;
    end

endmodule

// ----- frequency_order_sorter_top.f -----
hdl/fos_pkg.sv
hdl/fos_cell.sv
hdl/frequency_order_sorter_top.sv
dv/frequency_order_sorter_top_test.sv
